// ===== design/crc16gc_pkg.sv =====
// crc16gc_pkg: shared types and constants for the crc16 generate/check block
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package crc16gc_pkg;

  localparam int unsigned OutCrcW = 16;
  localparam int unsigned PolyW = 16;
  localparam logic [PolyW-1:0] PolyReset = 16'h0411;

  // one input request as held in the input register
  typedef struct packed {
    logic data_bit;
    logic error_bit;
    logic last_data;
  } item_t;

  // one result request
  typedef struct packed {
    logic [OutCrcW-1:0] crc_value;
    logic               pass;
  } result_t;

  // handshake between core and output register
  typedef struct packed {
    logic fire;
    logic res_valid;
  } step_ctl_t;

endpackage

// ===== design/crc16gc_in_stage.sv =====
// crc16gc_in_stage: input register of the crc16 block
// depends on crc16gc_pkg
`timescale 1ns / 1ps

module crc16gc_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  crc16gc_pkg::item_t  item_i,
  input  logic                take_i,
  output logic                item_valid_o,
  output crc16gc_pkg::item_t  item_o
);

  logic               valid_q, valid_d;
  crc16gc_pkg::item_t item_q;

  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o = item_q;

endmodule

// ===== design/crc16gc_core.sv =====
// crc16gc_core: sender and receiver lfsr steps, trailer counter, polynomial register
// depends on crc16gc_pkg
`timescale 1ns / 1ps

module crc16gc_core #(
  parameter int unsigned CRC_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [crc16gc_pkg::PolyW-1:0] cfg_poly_low_i,
  input  logic                          item_valid_i,
  input  crc16gc_pkg::item_t            item_i,
  input  logic                          out_free_i,
  output crc16gc_pkg::step_ctl_t        ctl_o,
  output crc16gc_pkg::result_t          result_o
);

  localparam int unsigned CW = (CRC_WIDTH < 8) ? 8 : ((CRC_WIDTH > 32) ? 32 : CRC_WIDTH);
  localparam int unsigned CntW = $clog2(CW);
  localparam logic [CntW-1:0] CntLast = CntW'(CW - 1);

  logic [crc16gc_pkg::PolyW-1:0] poly_q;
  logic [CW-1:0] send_rem_q, send_rem_d;
  logic [CW-1:0] recv_rem_q, recv_rem_d;
  logic [CW-1:0] crc_hold_q, crc_hold_d;
  logic          in_trailer_q, in_trailer_d;
  logic [CntW-1:0] count_q, count_d;

  logic [31:0]   poly_ext;
  logic [CW-1:0] poly_w;
  logic [31:0]   crc_ext;
  logic [CntW-1:0] pos;
  logic          fire;
  logic          rbit;
  logic          send_top;
  logic [CW-1:0] send_next;
  logic [CW-1:0] recv_next;
  logic          res_valid;

  assign poly_ext = 32'(poly_q);
  assign poly_w   = poly_ext[CW-1:0];
  assign crc_ext  = 32'(crc_hold_q);
  assign pos      = CntLast - count_q;
  assign fire     = item_valid_i && out_free_i;

  always_comb begin
    // receiver bit: message bit or stored crc bit, with error applied
    if (in_trailer_q) begin
      rbit = crc_hold_q[pos] ^ item_i.error_bit;
    end else begin
      rbit = item_i.data_bit ^ item_i.error_bit;
    end
    send_top  = send_rem_q[CW-1] ^ item_i.data_bit;
    send_next = {send_rem_q[CW-2:0], 1'b0} ^ (send_top ? poly_w : '0);
    recv_next = {recv_rem_q[CW-2:0], rbit} ^ (recv_rem_q[CW-1] ? poly_w : '0);
  end

  always_comb begin
    send_rem_d   = send_rem_q;
    recv_rem_d   = recv_rem_q;
    crc_hold_d   = crc_hold_q;
    in_trailer_d = in_trailer_q;
    count_d      = count_q;
    res_valid    = 1'b0;
    if (fire) begin
      recv_rem_d = recv_next;
      if (!in_trailer_q) begin
        send_rem_d = send_next;
        if (item_i.last_data) begin
          crc_hold_d   = send_next;
          send_rem_d   = '0;
          in_trailer_d = 1'b1;
          count_d      = '0;
        end
      end else if (count_q == CntLast) begin
        res_valid    = 1'b1;
        recv_rem_d   = '0;
        in_trailer_d = 1'b0;
        count_d      = '0;
      end else begin
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q       <= crc16gc_pkg::PolyReset;
      send_rem_q   <= '0;
      recv_rem_q   <= '0;
      crc_hold_q   <= '0;
      in_trailer_q <= 1'b0;
      count_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        poly_q <= cfg_poly_low_i;
      end
      send_rem_q   <= send_rem_d;
      recv_rem_q   <= recv_rem_d;
      crc_hold_q   <= crc_hold_d;
      in_trailer_q <= in_trailer_d;
      count_q      <= count_d;
    end
  end

  assign ctl_o.fire         = fire;
  assign ctl_o.res_valid    = res_valid;
  assign result_o.crc_value = crc_ext[crc16gc_pkg::OutCrcW-1:0];
  assign result_o.pass      = (recv_next == '0);

`ifndef SYNTH
  a_count_only_in_trailer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> in_trailer_q)
    else $error("trailer count nonzero outside trailer");

  a_send_clear_in_trailer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_trailer_q |-> (send_rem_q == '0))
    else $error("sender remainder not cleared in trailer");

  a_result_in_trailer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (in_trailer_q && fire && count_q == CntLast))
    else $error("result outside final trailer request");

  a_result_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |=> (!in_trailer_q && count_q == '0 && recv_rem_q == '0))
    else $error("state not returned to start after result");

  a_last_enters_trailer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !in_trailer_q && item_i.last_data) |=> (in_trailer_q && count_q == '0))
    else $error("last data bit did not start trailer");
`endif

endmodule

// ===== design/crc16gc_out_stage.sv =====
// crc16gc_out_stage: result register with valid/ready handshake
// depends on crc16gc_pkg
`timescale 1ns / 1ps

module crc16gc_out_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  crc16gc_pkg::step_ctl_t ctl_i,
  input  crc16gc_pkg::result_t   result_i,
  output logic                   free_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output crc16gc_pkg::result_t   result_o
);

  logic                 valid_q, valid_d;
  crc16gc_pkg::result_t result_q;
  logic                 load;

  assign free_o = !valid_q || out_ready_i;
  assign load   = ctl_i.fire && ctl_i.res_valid;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

// ===== design/crc16_generate_and_check.sv =====
// crc16_generate_and_check: bit-serial crc sender and receiver with error injection
// depends on crc16gc_pkg, crc16gc_in_stage, crc16gc_core, crc16gc_out_stage
//
//   channel  direction  signals
//   in       input      in_valid_i / in_ready_o, data_bit_i, error_bit_i, last_data_i
//   out      output     out_valid_o / out_ready_i, crc_value_o, pass_o
//   cfg      input      cfg_valid_i / cfg_ready_o, cfg_poly_low_i
//
// one request per cycle while the output register is free; a request waits in the
// input register until the lfsr step takes it, and its result, if any, is shown in
// the next cycle; the rate is set by the sender and receiver lfsr step
// reset clears the remainders, trailer state and sets the polynomial to 0x0411
// a stalled result holds the lfsr step; the input register still takes one request
`timescale 1ns / 1ps

module crc16_generate_and_check #(
  parameter int unsigned CRC_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                data_bit_i,
  input  logic                                error_bit_i,
  input  logic                                last_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [crc16gc_pkg::OutCrcW-1:0]     crc_value_o,
  output logic                                pass_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [crc16gc_pkg::PolyW-1:0]       cfg_poly_low_i
);

  crc16gc_pkg::item_t     in_item;
  crc16gc_pkg::item_t     held_item;
  logic                   held_valid;
  crc16gc_pkg::step_ctl_t ctl;
  crc16gc_pkg::result_t   core_result;
  crc16gc_pkg::result_t   out_result;
  logic                   out_free;

  assign in_item.data_bit  = data_bit_i;
  assign in_item.error_bit = error_bit_i;
  assign in_item.last_data = last_data_i;
  assign cfg_ready_o       = 1'b1;

  crc16gc_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .item_i       (in_item),
    .take_i       (ctl.fire),
    .item_valid_o (held_valid),
    .item_o       (held_item)
  );

  crc16gc_core #(
    .CRC_WIDTH (CRC_WIDTH)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_poly_low_i (cfg_poly_low_i),
    .item_valid_i   (held_valid),
    .item_i         (held_item),
    .out_free_i     (out_free),
    .ctl_o          (ctl),
    .result_o       (core_result)
  );

  crc16gc_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .result_i    (core_result),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_result)
  );

  assign crc_value_o = out_result.crc_value;
  assign pass_o      = out_result.pass;

endmodule

// ===== dv/tb_top.sv =====
// tb_top: self-checking testbench for crc16_generate_and_check, crc-16 msb first, zero init
// depends on crc16gc_pkg and the crc16_generate_and_check rtl; drives whole frames with error bits
// and checks each crc value and pass flag against a bit-serial predictor kept in this file
`timescale 1ns / 1ps

module tb_top;
  import crc16gc_pkg::*;

  localparam int CrcW = 16;
  localparam int unsigned CycleLimit = 400000;
  localparam logic [PolyW-1:0] PolyCcitt = 16'h1021;
  localparam logic [PolyW-1:0] PolyAnsi = 16'h8005;
  localparam logic [PolyW-1:0] PolyEvenLow = 16'h8004;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic data_bit_i = 1'b0;
  logic error_bit_i = 1'b0;
  logic last_data_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [OutCrcW-1:0] crc_value_o;
  logic pass_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [PolyW-1:0] cfg_poly_low_i = '0;

  // predictor state
  logic [CrcW-1:0] poly_model;
  logic [CrcW-1:0] gen_rem;
  logic [CrcW-1:0] chk_rem;
  logic [CrcW-1:0] crc_latched;
  logic trailer_on;
  int trailer_taken;
  result_t crc_expect_q[$];

  int n_errors = 0;
  int n_bits = 0;
  int n_frames_sent = 0;
  int n_results = 0;
  int n_pass_flags = 0;
  int n_polys = 0;
  int unsigned cycle_cnt = 0;
  int hold_req = 0;
  bit src_idle_en = 1'b0;
  bit sink_idle_en = 1'b0;

  crc16_generate_and_check #(
    .CRC_WIDTH(CrcW)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_bit_i    (data_bit_i),
    .error_bit_i   (error_bit_i),
    .last_data_i   (last_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .crc_value_o   (crc_value_o),
    .pass_o        (pass_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_poly_low_i(cfg_poly_low_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               crc_expect_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // sender side: remainder of message * x^16 mod g
  function automatic logic [CrcW-1:0] gen_shift(input logic [CrcW-1:0] r, input logic b,
                                                input logic [CrcW-1:0] p);
    logic top;
    top = r[CrcW-1] ^ b;
    r = r << 1;
    if (top) r = r ^ p;
    return r;
  endfunction

  // receiver side: long division of the received frame by g
  function automatic logic [CrcW-1:0] chk_shift(input logic [CrcW-1:0] r, input logic b,
                                                input logic [CrcW-1:0] p);
    logic top;
    top = r[CrcW-1];
    r = {r[CrcW-2:0], b};
    if (top) r = r ^ p;
    return r;
  endfunction

  function automatic void crc_frame_step(input logic d, input logic e, input logic last);
    result_t res;
    if (!trailer_on) begin
      gen_rem = gen_shift(gen_rem, d, poly_model);
      chk_rem = chk_shift(chk_rem, d ^ e, poly_model);
      if (last) begin
        crc_latched = gen_rem;
        gen_rem = '0;
        trailer_on = 1'b1;
        trailer_taken = 0;
      end
    end else begin
      chk_rem = chk_shift(chk_rem, crc_latched[CrcW-1-trailer_taken] ^ e, poly_model);
      trailer_taken++;
      if (trailer_taken == CrcW) begin
        res.crc_value = crc_latched;
        res.pass = (chk_rem == '0);
        crc_expect_q.push_back(res);
        chk_rem = '0;
        trailer_on = 1'b0;
        trailer_taken = 0;
      end
    end
  endfunction

  // accepted requests and register writes feed the predictor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_model = PolyReset;
      gen_rem = '0;
      chk_rem = '0;
      crc_latched = '0;
      trailer_on = 1'b0;
      trailer_taken = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) poly_model = cfg_poly_low_i;
      if (in_valid_i && in_ready_o) begin
        crc_frame_step(data_bit_i, error_bit_i, last_data_i);
        n_bits++;
      end
    end
  end

  task automatic report_mismatch(input string what, input logic [OutCrcW-1:0] got,
                                 input logic [OutCrcW-1:0] want);
    if (n_errors < 20)
      $display("mismatch at cycle %0d, result %0d: %s got 0x%0h expected 0x%0h",
               cycle_cnt, n_results, what, got, want);
    n_errors++;
  endtask

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (crc_expect_q.size() == 0) begin
        report_mismatch("unexpected result, crc", crc_value_o, '0);
      end else begin
        want = crc_expect_q.pop_front();
        if (crc_value_o !== want.crc_value)
          report_mismatch("crc_value", crc_value_o, want.crc_value);
        if (pass_o !== want.pass)
          report_mismatch("pass", OutCrcW'(pass_o), OutCrcW'(want.pass));
      end
      n_results++;
      if (pass_o === 1'b1) n_pass_flags++;
    end
  end

  // result side: random stalls plus the long hold-off
  initial begin : result_sink
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        stall_left = $urandom_range(0, 4);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_bit(input logic d, input logic e, input logic last);
    if (src_idle_en && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_bit_i <= d;
    error_bit_i <= e;
    last_data_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // frame bits go msb first; errs covers message and trailer positions
  task automatic send_frame(input logic [255:0] msg, input logic [271:0] errs, input int len);
    for (int i = 0; i < len; i++)
      send_bit(msg[len-1-i], errs[len+CrcW-1-i], i == len - 1);
    for (int j = 0; j < CrcW; j++)
      send_bit(1'($urandom_range(0, 1)), errs[CrcW-1-j], 1'($urandom_range(0, 1)));
    n_frames_sent++;
  endtask

  task automatic send_random_frame(input int len);
    logic [255:0] msg;
    logic [271:0] errs;
    int mode;
    for (int w = 0; w < 8; w++) msg[w*32 +: 32] = $urandom;
    errs = '0;
    mode = $urandom_range(0, 19);
    if (mode >= 17) begin
      for (int i = 0; i < len + CrcW; i++) errs[i] = ($urandom_range(0, 7) == 0);
    end else if (mode >= 12) begin
      errs[$urandom_range(0, len + CrcW - 1)] = 1'b1;
    end
    send_frame(msg, errs, len);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (crc_expect_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_poly(input logic [PolyW-1:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_poly_low_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    n_polys++;
  endtask

  task automatic test_reset_poly();
    send_frame(256'h1, '0, 1);
    send_frame(256'h1, '0, 4);
    send_frame(256'h0, '0, 8);
    send_frame(256'hffff, '0, 16);
    drain();
  endtask

  task automatic test_error_injection();
    send_frame(256'ha5, 272'h1 << 20, 8);
    send_frame(256'ha5, 272'h1 << 3, 8);
    send_frame(256'ha5, {272{1'b1}}, 8);
    drain();
  endtask

  task automatic test_poly_extremes();
    write_poly(16'hffff);
    send_frame(256'h3c, '0, 7);
    write_poly(16'h0000);
    send_frame(256'h5, '0, 3);
    send_frame(256'h5, 272'h1 << 17, 3);
    write_poly(PolyEvenLow);
    send_frame(256'hbeef, '0, 16);
    send_frame(256'hbeef, 272'h1 << 30, 16);
    write_poly(PolyReset);
  endtask

  task automatic test_output_backpressure();
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    hold_req = 150;
    for (int f = 0; f < 6; f++) send_random_frame($urandom_range(1, 3));
    drain();
  endtask

  task automatic test_random_frames();
    int len;
    int pick;
    while (n_bits < 1400 || n_frames_sent < 45) begin
      if (n_frames_sent % 6 == 0) begin
        pick = $urandom_range(0, 5);
        case (pick)
          0: write_poly(PolyW'($urandom_range(0, 65535)));
          1: write_poly(PolyCcitt);
          2: write_poly(PolyAnsi);
          3: write_poly(PolyW'($urandom_range(0, 65535)) & 16'hfffe);
          4: write_poly(16'hffff);
          default: write_poly(16'h0000);
        endcase
      end
      src_idle_en = ($urandom_range(0, 3) != 0);
      sink_idle_en = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 11) == 0) len = $urandom_range(100, 240);
      else len = $urandom_range(1, 20);
      send_random_frame(len);
    end
    drain();
  endtask

  task automatic test_back_to_back();
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    write_poly(PolyCcitt);
    for (int f = 0; f < 10; f++) send_random_frame($urandom_range(1, 12));
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    test_reset_poly();
    test_error_injection();
    test_poly_extremes();
    test_output_backpressure();
    test_random_frames();
    test_back_to_back();
    repeat (20) @(posedge clk_i);
    $display("%0d request bits in %0d frames, %0d polynomial writes", n_bits,
             n_frames_sent, n_polys);
    $display("%0d results checked, %0d with pass set, %0d mismatches", n_results,
             n_pass_flags, n_errors);
    if (n_errors == 0 && crc_expect_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
